[hdl/glzw_pkg.sv]
// Shared types, constants and helpers for the GIF LZW encoder.
package glzw_pkg;

    // Fixed field widths
    localparam int CODE_W  = 12;
    localparam int BITS_W  = 4;
    localparam int PIX_W   = 8;
    localparam int SIZE_W  = 4;
    // Generation tag carried by every hash slot
    localparam int EPOCH_W = 6;
    // Legal range of the symbol size
    localparam int SIZE_LO = 2;
    localparam int SIZE_HI = 8;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;      // load the accepted request
        logic wipe;         // write one cleared slot, advance sweep counter
        logic open;         // start an image: latch size, reset prefix, size the flush
        logic flush;        // reset code counter and width, new slot generation
        logic emit_clear;   // send the clear code
        logic take_pixel;   // pixel becomes the prefix
        logic probe_first;  // read the slot at the hash of (prefix, pixel)
        logic probe_step;   // read the following slot
        logic hit;          // matched slot code becomes the prefix
        logic emit_data;    // send the prefix code, advance the code counter
        logic insert;       // with emit_data: enter the pair, pixel becomes prefix
        logic emit_end;     // send the end code and close the image
    } glzw_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic emit_ok;      // output register can take a code
        logic started;      // image is open
        logic held;         // a prefix is held
        logic last;         // request marks the final pixel
        logic slot_empty;   // probed slot is free in this generation
        logic slot_match;   // probed slot holds (prefix, pixel)
        logic full;         // next data code triggers a clear
        logic epoch_last;   // next flush wraps the generation tag
        logic wipe_done;    // sweep counter at the final slot
    } glzw_stat_t;

    // Saturate the symbol size into its legal range
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        r = v;
        if (v < SIZE_W'(SIZE_LO))
            r = SIZE_W'(SIZE_LO);
        else if (v > SIZE_W'(SIZE_HI))
            r = SIZE_W'(SIZE_HI);
        return r;
    endfunction

endpackage

[hdl/glzw_ram.sv]
// Generic single-port RAM with registered read data.
module glzw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] storage_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and read the addressed word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            storage_reg[addr] <= wdata;
        end
        rdata_reg <= storage_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/glzw_ctrl.sv]
// Controller state machine of the GIF LZW encoder.
module glzw_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  glzw_pkg::glzw_stat_t  stat,
    output glzw_pkg::glzw_cmd_t   cmd
);

    typedef enum logic [9:0] {
        S_WIPE     = 10'b0000000001,
        S_IDLE     = 10'b0000000010,
        S_OPEN     = 10'b0000000100,
        S_OPEN_CLR = 10'b0000001000,
        S_PIX      = 10'b0000010000,
        S_PROBE    = 10'b0000100000,
        S_MISS     = 10'b0001000000,
        S_LAST     = 10'b0010000000,
        S_FULL     = 10'b0100000000,
        S_END      = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    state_t resume_reg, resume_next;
    logic   phase_reg, phase_next;     // 1 while the closing data code is out
    state_t post_state;

    assign in_ready = (state_reg == S_IDLE);

    // Where to go once a dictionary-full clear code has gone out
    always_comb
    begin
        if (phase_reg)
            post_state = S_END;
        else if (stat.last)
            post_state = S_LAST;
        else
            post_state = S_IDLE;
    end

    // Sequence one request
    always_comb
    begin
        cmd         = '0;
        state_next  = state_reg;
        resume_next = resume_reg;
        phase_next  = phase_reg;
        case (state_reg)
            S_WIPE:
            begin
                cmd.wipe = 1'b1;
                if (stat.wipe_done)
                    state_next = resume_reg;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = stat.started ? S_PIX : S_OPEN;
                end
            end
            S_OPEN:
            begin
                cmd.open  = 1'b1;
                cmd.flush = 1'b1;
                if (stat.epoch_last)
                begin
                    state_next  = S_WIPE;
                    resume_next = S_OPEN_CLR;
                end
                else
                begin
                    state_next = S_OPEN_CLR;
                end
            end
            S_OPEN_CLR:
            begin
                if (stat.emit_ok)
                begin
                    cmd.emit_clear = 1'b1;
                    state_next     = S_PIX;
                end
            end
            S_PIX:
            begin
                if (!stat.held)
                begin
                    cmd.take_pixel = 1'b1;
                    state_next     = stat.last ? S_LAST : S_IDLE;
                end
                else
                begin
                    cmd.probe_first = 1'b1;
                    state_next      = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (stat.slot_empty)
                begin
                    state_next = S_MISS;
                end
                else if (stat.slot_match)
                begin
                    cmd.hit    = 1'b1;
                    state_next = stat.last ? S_LAST : S_IDLE;
                end
                else
                begin
                    cmd.probe_step = 1'b1;
                end
            end
            S_MISS:
            begin
                if (stat.emit_ok)
                begin
                    cmd.emit_data = 1'b1;
                    cmd.insert    = 1'b1;
                    phase_next    = 1'b0;
                    if (stat.full)
                        state_next = S_FULL;
                    else
                        state_next = stat.last ? S_LAST : S_IDLE;
                end
            end
            S_LAST:
            begin
                if (stat.emit_ok)
                begin
                    cmd.emit_data = 1'b1;
                    phase_next    = 1'b1;
                    state_next    = stat.full ? S_FULL : S_END;
                end
            end
            S_FULL:
            begin
                if (stat.emit_ok)
                begin
                    cmd.emit_clear = 1'b1;
                    cmd.flush      = 1'b1;
                    if (stat.epoch_last)
                    begin
                        state_next  = S_WIPE;
                        resume_next = post_state;
                    end
                    else
                    begin
                        state_next = post_state;
                    end
                end
            end
            S_END:
            begin
                if (stat.emit_ok)
                begin
                    cmd.emit_end = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state; sweep the slot memory after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_WIPE;
            resume_reg <= S_IDLE;
            phase_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            resume_reg <= resume_next;
            phase_reg  <= phase_next;
        end
    end

endmodule

[hdl/glzw_datapath.sv]
// Datapath of the GIF LZW encoder: code state, hash slot memory and output register.
module glzw_datapath #(
    parameter int MAX_CODE_BITS = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [3:0]            cfg_wr_data,
    input  logic [7:0]            pixel,
    input  logic                  is_last,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [11:0]           code,
    output logic [3:0]            code_bits,
    output logic                  last_code,
    input  glzw_pkg::glzw_cmd_t   cmd,
    output glzw_pkg::glzw_stat_t  stat
);

    localparam int CODE_W  = glzw_pkg::CODE_W;
    localparam int BITS_W  = glzw_pkg::BITS_W;
    localparam int PIX_W   = glzw_pkg::PIX_W;
    localparam int SIZE_W  = glzw_pkg::SIZE_W;
    localparam int EPOCH_W = glzw_pkg::EPOCH_W;
    localparam int MCB     = MAX_CODE_BITS;
    localparam int NFC_W   = MCB + 1;              // next free code reaches 2^MCB + 1
    localparam int SLOT_AW = MCB + 1;              // twice as many slots as codes
    localparam int KEY_W   = MCB + PIX_W;
    localparam int SUF_LSB = MCB;
    localparam int PRE_LSB = MCB + PIX_W;
    localparam int EP_LSB  = 2 * MCB + PIX_W;
    localparam int SLOT_W  = EP_LSB + EPOCH_W;

    logic [SIZE_W-1:0]  code_size_reg;
    logic [PIX_W-1:0]   pix_reg;
    logic               last_reg;
    logic [SIZE_W-1:0]  size_reg, size_next;
    logic               started_reg, started_next;
    logic               held_reg, held_next;
    logic [MCB-1:0]     prefix_reg, prefix_next;
    logic [NFC_W-1:0]   nfc_reg, nfc_next;
    logic [BITS_W-1:0]  width_reg, width_next;
    logic [EPOCH_W-1:0] epoch_reg, epoch_next;
    logic [SLOT_AW-1:0] probe_addr_reg, probe_addr_next;
    logic [SLOT_AW-1:0] wipe_addr_reg;
    logic               out_valid_reg;
    logic [CODE_W-1:0]  code_reg;
    logic [BITS_W-1:0]  bits_reg;
    logic               last_code_reg;

    logic [PIX_W-1:0]   sym;
    logic [KEY_W-1:0]   key;
    logic [SLOT_AW-1:0] hash;
    logic [SIZE_W-1:0]  open_size;
    logic [SIZE_W-1:0]  flush_size;
    logic [CODE_W-1:0]  clear_code;
    logic               grow_point;
    logic               emit_any;
    logic               insert_en;
    logic               ram_we;
    logic [SLOT_AW-1:0] ram_addr;
    logic [SLOT_W-1:0]  ram_wdata;
    logic [SLOT_W-1:0]  ram_rdata;
    logic [EPOCH_W-1:0] slot_epoch;
    logic [MCB-1:0]     slot_prefix;
    logic [PIX_W-1:0]   slot_suffix;
    logic [MCB-1:0]     slot_code;

    // Mask the pixel to the active symbol size
    assign sym = pix_reg & PIX_W'(((PIX_W+1)'(1) << size_reg) - (PIX_W+1)'(1));

    // Fold the (prefix, pixel) key into a slot address
    assign key  = {prefix_reg, sym};
    assign hash = key[SLOT_AW-1:0] ^ SLOT_AW'(key >> SLOT_AW);

    // Split the probed slot
    assign slot_code   = ram_rdata[MCB-1:0];
    assign slot_suffix = ram_rdata[SUF_LSB +: PIX_W];
    assign slot_prefix = ram_rdata[PRE_LSB +: MCB];
    assign slot_epoch  = ram_rdata[EP_LSB +: EPOCH_W];

    assign open_size  = glzw_pkg::clamp_size(code_size_reg);
    assign flush_size = cmd.open ? open_size : size_reg;
    assign clear_code = CODE_W'(1) << size_reg;
    assign grow_point = (nfc_reg == (NFC_W'(1) << width_reg));
    assign emit_any   = cmd.emit_clear || cmd.emit_data || cmd.emit_end;

    // Enter the pair only while codes remain
    assign insert_en = cmd.emit_data && cmd.insert && !nfc_reg[NFC_W-1];

    // Slot memory access: sweep, probe or insert
    always_comb
    begin
        ram_we    = cmd.wipe || insert_en;
        ram_wdata = {epoch_reg, prefix_reg, sym, nfc_reg[MCB-1:0]};
        ram_addr  = probe_addr_reg;
        if (cmd.wipe)
        begin
            ram_addr  = wipe_addr_reg;
            ram_wdata = '0;
        end
        else if (cmd.probe_first)
        begin
            ram_addr = hash;
        end
        else if (cmd.probe_step)
        begin
            ram_addr = probe_addr_reg + SLOT_AW'(1);
        end
    end

    glzw_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (2 ** SLOT_AW)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Update code state
    always_comb
    begin
        size_next       = size_reg;
        started_next    = started_reg;
        held_next       = held_reg;
        prefix_next     = prefix_reg;
        nfc_next        = nfc_reg;
        width_next      = width_reg;
        epoch_next      = epoch_reg;
        probe_addr_next = ram_addr;
        if (cmd.open)
        begin
            size_next    = open_size;
            started_next = 1'b1;
            held_next    = 1'b0;
            prefix_next  = '0;
        end
        if (cmd.flush)
        begin
            nfc_next   = (NFC_W'(1) << flush_size) + NFC_W'(2);
            width_next = BITS_W'(flush_size) + BITS_W'(1);
            epoch_next = (epoch_reg == '1) ? EPOCH_W'(1) : epoch_reg + EPOCH_W'(1);
        end
        if (cmd.take_pixel)
        begin
            prefix_next = MCB'(sym);
            held_next   = 1'b1;
        end
        if (cmd.hit)
        begin
            prefix_next = slot_code;
        end
        if (cmd.emit_data)
        begin
            nfc_next = nfc_reg + NFC_W'(1);
            if (grow_point && (width_reg < BITS_W'(MCB)))
                width_next = width_reg + BITS_W'(1);
            if (cmd.insert)
                prefix_next = MCB'(sym);
        end
        if (cmd.emit_end)
        begin
            started_next = 1'b0;
            held_next    = 1'b0;
            prefix_next  = '0;
        end
    end

    // Hold configuration and code state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_size_reg  <= SIZE_W'(glzw_pkg::SIZE_HI);
            size_reg       <= SIZE_W'(glzw_pkg::SIZE_HI);
            started_reg    <= 1'b0;
            held_reg       <= 1'b0;
            prefix_reg     <= '0;
            nfc_reg        <= (NFC_W'(1) << glzw_pkg::SIZE_HI) + NFC_W'(2);
            width_reg      <= BITS_W'(glzw_pkg::SIZE_HI + 1);
            epoch_reg      <= EPOCH_W'(1);
            probe_addr_reg <= '0;
            wipe_addr_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                code_size_reg <= cfg_wr_data;
            size_reg       <= size_next;
            started_reg    <= started_next;
            held_reg       <= held_next;
            prefix_reg     <= prefix_next;
            nfc_reg        <= nfc_next;
            width_reg      <= width_next;
            epoch_reg      <= epoch_next;
            probe_addr_reg <= probe_addr_next;
            if (cmd.wipe)
                wipe_addr_reg <= wipe_addr_reg + SLOT_AW'(1);
        end
    end

    // Latch the accepted request
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pix_reg  <= pixel;
            last_reg <= is_last;
        end
    end

    // Output register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit_any)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Load the outgoing code
    always_ff @(posedge clk)
    begin
        if (emit_any)
        begin
            bits_reg <= width_reg;
            if (cmd.emit_data)
            begin
                code_reg      <= CODE_W'(prefix_reg);
                last_code_reg <= 1'b0;
            end
            else if (cmd.emit_end)
            begin
                code_reg      <= clear_code + CODE_W'(1);
                last_code_reg <= 1'b1;
            end
            else
            begin
                code_reg      <= clear_code;
                last_code_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign code      = code_reg;
    assign code_bits = bits_reg;
    assign last_code = last_code_reg;

    // Report status
    always_comb
    begin
        stat.emit_ok    = !out_valid_reg || out_ready;
        stat.started    = started_reg;
        stat.held       = held_reg;
        stat.last       = last_reg;
        stat.slot_empty = (slot_epoch != epoch_reg);
        stat.slot_match = (slot_epoch == epoch_reg) && (slot_prefix == prefix_reg)
                          && (slot_suffix == sym);
        stat.full       = grow_point && (width_reg >= BITS_W'(MCB));
        stat.epoch_last = (epoch_reg == '1);
        stat.wipe_done  = (wipe_addr_reg == '1);
    end

endmodule

[hdl/gif_lzw_encoder_unit.sv]
// A held pixel found on the first slot probe goes from acceptance through the pixel and probe
// states back to idle; each further probe, each code sent and any output stall lengthen this. The first pixel of an
// image also passes through open and clear code before the pixel is taken. One slot probe per cycle sets the rate.
// Reset is asynchronous and active low; afterwards the slot memory is swept over
// all 2^(MAX_CODE_BITS+1) slots before the first request, and the same sweep follows
// every 63rd dictionary flush.
module gif_lzw_encoder_unit #(
    parameter int MAX_CODE_BITS = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  pixel,
    input  logic        is_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [11:0] code,
    output logic [3:0]  code_bits,
    output logic        last_code
);

    glzw_pkg::glzw_cmd_t  cmd;
    glzw_pkg::glzw_stat_t stat;

    // Sequence each request
    glzw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold code state, dictionary slots and the output register
    glzw_datapath #(
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .pixel       (pixel),
        .is_last     (is_last),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .code        (code),
        .code_bits   (code_bits),
        .last_code   (last_code),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

[hdl/glzw_checker.sv]
// Port-level assertions for the GIF LZW encoder, bound to the top level.
module glzw_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [11:0] code,
    input logic [3:0]  code_bits,
    input logic        last_code
);

    // Drop ready in the cycle after a request is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("in_ready stayed high after a request was taken");

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(code) && $stable(code_bits)
                                       && $stable(last_code)))
        else $error("stalled result changed");

    // Every code fits in its stated width
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((code >> code_bits) == 12'd0) && (code_bits >= 4'd3)
                      && (code_bits <= 4'd12))
        else $error("code does not fit its width");

    // The end code is odd and no less than 5, as the clear code plus one must be
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_code) |-> code[0] && (code >= 12'd5))
        else $error("end code malformed");

endmodule

bind gif_lzw_encoder_unit glzw_checker u_glzw_checker (.*);

[test/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the GIF LZW encoder unit: directed images and random images.
module tb_top;

    localparam int CODE_W    = glzw_pkg::CODE_W;
    localparam int BITS_W    = glzw_pkg::BITS_W;
    localparam int PIX_W     = glzw_pkg::PIX_W;
    localparam int SIZE_W    = glzw_pkg::SIZE_W;
    localparam int SIZE_LO   = glzw_pkg::SIZE_LO;
    localparam int SIZE_HI   = glzw_pkg::SIZE_HI;
    localparam int MAX_BITS  = 12;
    localparam int STEP_CAP  = 5;
    localparam int CYCLE_CAP = 2000000;
    localparam int SETTLE    = 64;
    localparam int DRAIN_CAP = 40000;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [BITS_W-1:0] bits;
        logic              last;
    } lzw_code_t;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic [SIZE_W-1:0] cfg_wr_data = '0;
    logic              in_valid    = 1'b0;
    logic              in_ready;
    logic [PIX_W-1:0]  pixel       = '0;
    logic              is_last     = 1'b0;
    logic              out_valid;
    logic              out_ready   = 1'b0;
    logic [CODE_W-1:0] code;
    logic [BITS_W-1:0] code_bits;
    logic              last_code;

    // Encoder model state
    logic [SIZE_W-1:0] size_reg     = SIZE_W'(8);
    int                act_size     = 8;
    int                next_code;
    int                width_now;
    int                prefix_code  = 0;
    bit                prefix_valid = 1'b0;
    bit                image_open   = 1'b0;
    int                pair_table[int];
    int                step_count;
    lzw_code_t         pending_codes[$];

    int errors     = 0;
    int cycles     = 0;
    bit no_gap_run = 1'b0;

    gif_lzw_encoder_unit #(
        .MAX_CODE_BITS(MAX_BITS)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pixel      (pixel),
        .is_last    (is_last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .code       (code),
        .code_bits  (code_bits),
        .last_code  (last_code)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
    end

    // Abort a hung run
    initial
    begin
        wait (cycles > CYCLE_CAP);
        $display("tb_top: errors");
        $finish;
    end

    // Saturate the symbol size to its legal range
    function automatic int sat_size(input logic [SIZE_W-1:0] v);
        if (v < SIZE_LO)
            return SIZE_LO;
        if (v > SIZE_HI)
            return SIZE_HI;
        return int'(v);
    endfunction

    function automatic void push_code(input int c, input int b, input bit l);
        lzw_code_t w;
        if (step_count >= STEP_CAP)
            return;
        w.code = CODE_W'(c);
        w.bits = BITS_W'(b);
        w.last = l;
        pending_codes.push_back(w);
        step_count++;
    endfunction

    function automatic void restart_dict();
        pair_table.delete();
        next_code = (1 << act_size) + 2;
        width_now = act_size + 1;
    endfunction

    // Send one code, enter the new pair, grow the width or clear at the limit
    function automatic void send_code(input int c, input bit add, input int sfx);
        push_code(c, width_now, 1'b0);
        if (add && next_code < (1 << MAX_BITS))
            pair_table[(c << 8) | sfx] = next_code;
        next_code++;
        if (next_code == (1 << width_now) + 1)
        begin
            if (width_now >= MAX_BITS)
            begin
                push_code(1 << act_size, width_now, 1'b0);
                restart_dict();
            end
            else
            begin
                width_now++;
            end
        end
    endfunction

    // Work out the codes that one accepted pixel request causes
    function automatic void lzw_predict(input logic [PIX_W-1:0] pix, input logic fin);
        int p;
        int key;
        step_count = 0;
        if (!image_open)
        begin
            act_size = sat_size(size_reg);
            restart_dict();
            prefix_valid = 1'b0;
            prefix_code  = 0;
            push_code(1 << act_size, width_now, 1'b0);
            image_open = 1'b1;
        end
        p = int'(pix) & ((1 << act_size) - 1);
        if (!prefix_valid)
        begin
            prefix_code  = p;
            prefix_valid = 1'b1;
        end
        else
        begin
            key = (prefix_code << 8) | p;
            if (pair_table.exists(key))
            begin
                prefix_code = pair_table[key];
            end
            else
            begin
                send_code(prefix_code, 1'b1, p);
                prefix_code = p;
            end
        end
        if (fin)
        begin
            send_code(prefix_code, 1'b0, 0);
            push_code((1 << act_size) + 1, width_now, 1'b1);
            image_open   = 1'b0;
            prefix_valid = 1'b0;
            prefix_code  = 0;
            act_size     = sat_size(size_reg);
            restart_dict();
        end
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    // Compare each accepted code with the oldest expected one
    always @(posedge clk)
    begin
        lzw_code_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_codes.size() == 0)
            begin
                $error("unexpected code %0d, bits %0d, last_code %0b", code, code_bits,
                       last_code);
                errors++;
            end
            else
            begin
                want = pending_codes.pop_front();
                if (code !== want.code)
                begin
                    $error("code: expected %0d, actual %0d", want.code, code);
                    errors++;
                end
                if (code_bits !== want.bits)
                begin
                    $error("code_bits: expected %0d, actual %0d", want.bits, code_bits);
                    errors++;
                end
                if (last_code !== want.last)
                begin
                    $error("last_code: expected %0b, actual %0b", want.last, last_code);
                    errors++;
                end
            end
        end
    end

    // Stall the result side at random, with some long stretches of no stall
    initial
    begin : ready_gen
        int n;
        @(negedge clk);
        forever
        begin
            n = pick_gap();
            if (n > 0)
            begin
                out_ready <= 1'b0;
                repeat (n) @(negedge clk);
            end
            out_ready <= 1'b1;
            if ($urandom_range(0, 19) == 0)
                repeat ($urandom_range(100, 300)) @(negedge clk);
            else
                repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    end

    // Send one pixel request and predict its codes on acceptance
    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fin);
        int gap;
        gap = no_gap_run ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        pixel    <= pix;
        is_last  <= fin;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        lzw_predict(pix, fin);
        @(negedge clk);
    endtask

    // Hold off requests until every expected code has come, then settle
    task automatic drain_idle(input int extra);
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        do
        begin
            @(negedge clk);
            waited++;
        end
        while (pending_codes.size() != 0 && waited < DRAIN_CAP);
        repeat (extra) @(negedge clk);
    endtask

    task automatic write_size(input logic [SIZE_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        size_reg = v;
        @(negedge clk);
    endtask

    // Reset value of the size, with repeated pairs
    task automatic test_default_size();
        send_pixel(8'h00, 1'b0);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'h00, 1'b0);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'h00, 1'b1);
    endtask

    // Image of one pixel, masked to the smallest size
    task automatic test_lone_pixel();
        drain_idle(SETTLE);
        write_size(SIZE_W'(2));
        send_pixel(8'hFF, 1'b1);
    endtask

    // Sizes outside 2..8 saturate
    task automatic test_size_saturation();
        drain_idle(SETTLE);
        write_size(SIZE_W'(0));
        send_pixel(8'hFE, 1'b0);
        send_pixel(8'h01, 1'b0);
        send_pixel(8'h02, 1'b1);
        drain_idle(SETTLE);
        write_size(SIZE_W'(15));
        send_pixel(8'h80, 1'b0);
        send_pixel(8'h7F, 1'b1);
        drain_idle(SETTLE);
        write_size(SIZE_W'(1));
        send_pixel(8'hAA, 1'b1);
    endtask

    // A size written within an image waits for the next image
    task automatic test_late_size_write();
        drain_idle(SETTLE);
        write_size(SIZE_W'(8));
        send_pixel(8'h12, 1'b0);
        send_pixel(8'h34, 1'b0);
        drain_idle(SETTLE);
        write_size(SIZE_W'(3));
        send_pixel(8'h12, 1'b0);
        send_pixel(8'h34, 1'b0);
        send_pixel(8'h12, 1'b1);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'h07, 1'b1);
    endtask

    // Random images over a range of sizes
    task automatic test_random_images();
        logic [SIZE_W-1:0] sizes[10];
        logic [PIX_W-1:0]  syms[3];
        logic [PIX_W-1:0]  pix;
        int                sent;
        int                len;
        int                mask;
        bit                narrow;
        sizes = '{SIZE_W'(2), SIZE_W'(8), SIZE_W'(0), SIZE_W'(15), SIZE_W'(1),
                  SIZE_W'(9), SIZE_W'(4), SIZE_W'(6), SIZE_W'(3), SIZE_W'(7)};
        for (int k = 6; k < 10; k++)
            sizes[k] = SIZE_W'($urandom_range(0, 15));
        for (int ph = 0; ph < 10; ph++)
        begin
            drain_idle(SETTLE);
            write_size(sizes[ph]);
            mask = (1 << sat_size(sizes[ph])) - 1;
            sent = 0;
            while (sent < 14)
            begin
                len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 12)
                                                 : $urandom_range(13, 60);
                narrow = ($urandom_range(0, 1) == 1);
                for (int k = 0; k < 3; k++)
                    syms[k] = PIX_W'($urandom);
                // pause now and then until the block has caught up
                if ($urandom_range(0, 5) == 0)
                    drain_idle(0);
                no_gap_run = ($urandom_range(0, 4) == 0);
                for (int i = 0; i < len; i++)
                begin
                    pix = PIX_W'($urandom);
                    if (narrow)
                        pix = (pix & PIX_W'(~mask)) | (syms[$urandom_range(0, 2)] & PIX_W'(mask));
                    send_pixel(pix, i == len - 1);
                end
                no_gap_run = 1'b0;
                sent += len;
            end
        end
    endtask

    initial
    begin
        restart_dict();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_default_size();
        test_lone_pixel();
        test_size_saturation();
        test_late_size_write();
        test_random_images();

        drain_idle(SETTLE);
        if (pending_codes.size() != 0)
        begin
            $error("%0d expected codes never arrived", pending_codes.size());
            errors++;
        end
        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
